FILE: rtl/tracker_link_stats_table_top_defines.svh
// Assertion helpers
`ifndef TRACKER_LINK_STATS_TABLE_TOP_DEFINES_SVH
`define TRACKER_LINK_STATS_TABLE_TOP_DEFINES_SVH
`define TLS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TLS_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

FILE: rtl/tls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tls_pkg;
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_STATUS = 2'd1,
    OP_TICK   = 2'd2,
    OP_EMIT   = 2'd3
  } op_e;

  localparam logic [1:0] CFG_LIVE  = 2'd0;
  localparam logic [1:0] CFG_LINK  = 2'd1;
  localparam logic [1:0] CFG_EVICT = 2'd2;

  localparam logic [31:0] LIVE_RST  = 32'd3000;
  localparam logic [31:0] LINK_RST  = 32'd500;
  localparam logic [31:0] EVICT_RST = 32'd30000;
  localparam logic [16:0] SEQ_STALE_LIMIT = 17'h08000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] tracker_id;
    logic [15:0] seq_number;
    logic [31:0] now_ms;
    logic [15:0] battery_mv;
    logic [7:0]  ver_hi;
    logic [7:0]  ver_mid;
    logic [7:0]  ver_lo;
    logic [7:0]  tracker_mode;
    logic        sim_active;
  } in_t;

  typedef struct packed {
    logic        record_kind;
    logic        is_last;
    logic [15:0] record_id;
    logic [31:0] time_ms;
    logic [15:0] packet_rate;
    logic [3:0]  live_count;
    logic [31:0] lost_total;
    logic [15:0] report_mv;
    logic [23:0] fw_version;
    logic [7:0]  report_mode;
    logic        flag_bit;
  } out_t;

  typedef struct packed {
    logic        has_seq;
    logic [15:0] id;
    logic [31:0] seen_ms;
    logic [15:0] prev_seq;
    logic [31:0] lost;
    logic [15:0] count;
    logic [15:0] rate;
    logic [47:0] info;
  } slot_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_t;
endpackage
`default_nettype wire

FILE: rtl/tls_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tls_in_if;
  logic          valid;
  logic          ready;
  tls_pkg::in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tls_out_if;
  logic          valid;
  logic          ready;
  tls_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tls_cfg_if;
  logic          valid;
  logic          ready;
  tls_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/tls_slot_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module tls_slot_ram #(
  parameter int unsigned SLOTS = 8,
  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  tls_pkg::slot_t     wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output tls_pkg::slot_t     rdata_o
);
  tls_pkg::slot_t mem_q [SLOTS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: rtl/tls_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module tls_ctrl #(
  parameter int unsigned SLOTS = 8,
  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int unsigned CW = $clog2(SLOTS + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  tls_in_if.sink             in_if,
  tls_out_if.source          out_if,
  input  wire logic [31:0]   live_ms_i,
  input  wire logic [31:0]   link_ms_i,
  input  wire logic [31:0]   evict_ms_i,
  output logic               we_o,
  output logic [AW-1:0]      waddr_o,
  output tls_pkg::slot_t     wdata_o,
  output logic [AW-1:0]      raddr_o,
  input  tls_pkg::slot_t     rdata_i
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_UPD   = 7'b0000100,
    S_TICK  = 7'b0001000,
    S_SUM   = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_WAIT  = 7'b1000000
  } state_e;

  state_e          state_q, state_d;
  tls_pkg::in_t    item_q;
  logic [SLOTS-1:0] valid_q;
  logic [AW:0]     idx_q;
  logic            rd_pend_q;
  logic [AW-1:0]   rd_idx_q;
  logic            hit_q, free_f_q, stale_f_q;
  logic [AW-1:0]   hit_i_q, free_i_q, stale_i_q;
  logic [31:0]     all_count_q;
  logic [15:0]     all_rate_q;
  logic [CW-1:0]   live_q;
  logic            out_valid_q;
  tls_pkg::out_t   out_q;

  logic [32:0] age_w;
  logic        age_neg, age_gt_evict, age_lt_live, age_lt_link;
  logic [31:0] age_pos;

  assign age_w = {1'b0, item_q.now_ms} - {1'b0, rdata_i.seen_ms};
  assign age_neg = age_w[32];
  assign age_pos = age_neg ? 32'd0 : age_w[31:0];
  assign age_gt_evict = !age_neg && (age_w[31:0] > evict_ms_i);
  assign age_lt_live = age_neg || (age_w[31:0] < live_ms_i);
  assign age_lt_link = age_neg || (age_w[31:0] < link_ms_i);

  logic [AW-1:0] tgt;
  logic          tgt_ok, tgt_new;
  always_comb begin
    tgt_ok = 1'b1;
    tgt_new = 1'b0;
    if (hit_q) begin
      tgt = hit_i_q;
    end else if (free_f_q) begin
      tgt = free_i_q;
      tgt_new = 1'b1;
    end else begin
      tgt = stale_i_q;
      tgt_new = 1'b1;
      tgt_ok = stale_f_q;
    end
  end

  logic last_rec;
  always_comb begin
    last_rec = 1'b1;
    for (int j = 0; j < SLOTS; j++) begin
      if (j > int'(rd_idx_q) && valid_q[j]) last_rec = 1'b0;
    end
  end

  tls_pkg::slot_t upd;
  logic [16:0] step;
  always_comb begin
    upd = rdata_i;
    step = {1'b0, item_q.seq_number - rdata_i.prev_seq};
    if (tgt_new) upd = '0;
    upd.id = item_q.tracker_id;
    upd.seen_ms = item_q.now_ms;
    if (item_q.opcode == tls_pkg::OP_SAMPLE) begin
      step = {1'b0, item_q.seq_number - upd.prev_seq};
      if (upd.count != 16'hFFFF) upd.count = upd.count + 16'd1;
      if (!upd.has_seq) begin
        upd.has_seq = 1'b1;
        upd.prev_seq = item_q.seq_number;
      end else if (step != 17'd0 && step <= tls_pkg::SEQ_STALE_LIMIT) begin
        upd.lost = upd.lost + 32'(step) - 32'd1;
        upd.prev_seq = item_q.seq_number;
      end
    end else begin
      upd.info = {item_q.battery_mv, item_q.ver_hi, item_q.ver_mid,
                  item_q.ver_lo, item_q.tracker_mode};
    end
  end

  tls_pkg::slot_t tick_w;
  always_comb begin
    tick_w = rdata_i;
    tick_w.rate = rdata_i.count;
    tick_w.count = 16'd0;
  end

  assign in_if.ready = (state_q == S_IDLE);
  assign out_if.valid = out_valid_q;
  assign out_if.data = out_q;
  logic out_free;
  assign out_free = !out_valid_q || out_if.ready;

  logic scan_done;
  assign scan_done = (idx_q == (AW+1)'(SLOTS));

  always_comb begin
    state_d = state_q;
    raddr_o = idx_q[AW-1:0];
    we_o = 1'b0;
    waddr_o = rd_idx_q;
    wdata_o = tick_w;
    unique case (state_q)
      S_IDLE: begin
        raddr_o = '0;
        if (in_if.valid) begin
          if (in_if.data.opcode == tls_pkg::OP_SAMPLE ||
              in_if.data.opcode == tls_pkg::OP_STATUS) state_d = S_SCAN;
          else if (in_if.data.opcode == tls_pkg::OP_TICK) state_d = S_TICK;
          else state_d = S_SUM;
        end
      end
      S_SCAN: begin
        if (scan_done && !rd_pend_q) begin
          state_d = S_UPD;
          raddr_o = tgt;
        end
      end
      S_UPD: begin
        if (rd_pend_q) begin
          we_o = tgt_ok;
          waddr_o = tgt;
          wdata_o = upd;
          state_d = S_IDLE;
        end else begin
          raddr_o = tgt;
        end
      end
      S_TICK: begin
        we_o = rd_pend_q && valid_q[rd_idx_q];
        if (scan_done && !rd_pend_q) state_d = S_SUM;
      end
      S_SUM: begin
        if (scan_done && !rd_pend_q && out_free) state_d = S_EMIT;
      end
      S_EMIT: begin
        // hold the read on the stalled slot
        if (rd_pend_q && valid_q[rd_idx_q] && !out_free) raddr_o = rd_idx_q;
        if (scan_done && !rd_pend_q && out_free) state_d = S_WAIT;
      end
      S_WAIT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  logic emit_go;
  assign emit_go = (state_q == S_EMIT) && rd_pend_q && valid_q[rd_idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      idx_q <= '0;
      rd_pend_q <= 1'b0;
      all_count_q <= '0;
      all_rate_q <= '0;
      out_valid_q <= 1'b0;
      hit_q <= 1'b0;
      free_f_q <= 1'b0;
      stale_f_q <= 1'b0;
      live_q <= '0;
    end else begin
      state_q <= state_d;
      if (out_if.ready) out_valid_q <= 1'b0;
      rd_pend_q <= 1'b0;
      if (state_q == S_IDLE) begin
        idx_q <= '0;
        hit_q <= 1'b0;
        free_f_q <= 1'b0;
        stale_f_q <= 1'b0;
        live_q <= '0;
        if (in_if.valid) begin
          if (in_if.data.opcode == tls_pkg::OP_SAMPLE ||
              in_if.data.opcode == tls_pkg::OP_STATUS) begin
            all_count_q <= all_count_q + 32'd1;
          end else if (in_if.data.opcode == tls_pkg::OP_TICK) begin
            all_rate_q <= (all_count_q > 32'hFFFF) ? 16'hFFFF : all_count_q[15:0];
            all_count_q <= '0;
          end
        end
      end
      if ((state_q == S_SCAN || state_q == S_TICK || state_q == S_SUM ||
           state_q == S_EMIT) && !scan_done &&
          !(state_q == S_EMIT && rd_pend_q && valid_q[rd_idx_q] && !out_free)) begin
        idx_q <= idx_q + 1'b1;
        rd_pend_q <= 1'b1;
      end
      if (state_q == S_EMIT && rd_pend_q && valid_q[rd_idx_q] && !out_free) begin
        rd_pend_q <= 1'b1;
      end
      if (state_q == S_SCAN && rd_pend_q) begin
        if (valid_q[rd_idx_q]) begin
          if (rdata_i.id == item_q.tracker_id && !hit_q) begin
            hit_q <= 1'b1;
          end
          if (age_gt_evict && !stale_f_q) stale_f_q <= 1'b1;
        end else if (!free_f_q) begin
          free_f_q <= 1'b1;
        end
      end
      if (state_q == S_UPD) begin
        if (!rd_pend_q) rd_pend_q <= 1'b1;
        else if (tgt_ok) valid_q[tgt] <= 1'b1;
      end
      if (state_q == S_TICK && rd_pend_q && valid_q[rd_idx_q] && age_gt_evict) begin
        valid_q[rd_idx_q] <= 1'b0;
      end
      if (state_q == S_TICK && state_d == S_SUM) idx_q <= '0;
      if (state_q == S_SUM && rd_pend_q && valid_q[rd_idx_q] && age_lt_live) begin
        live_q <= live_q + 1'b1;
      end
      if (state_d == S_EMIT && state_q == S_SUM) begin
        idx_q <= '0;
        out_valid_q <= 1'b1;
      end
      if (emit_go && out_free) out_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_if.valid) item_q <= in_if.data;
    if (!(state_q == S_EMIT && rd_pend_q && valid_q[rd_idx_q] && !out_free)) begin
      rd_idx_q <= idx_q[AW-1:0];
    end
    if (state_q == S_SCAN && rd_pend_q) begin
      if (valid_q[rd_idx_q]) begin
        if (rdata_i.id == item_q.tracker_id && !hit_q) hit_i_q <= rd_idx_q;
        if (age_gt_evict && !stale_f_q) stale_i_q <= rd_idx_q;
      end else if (!free_f_q) begin
        free_i_q <= rd_idx_q;
      end
    end
    if (state_q == S_SUM && state_d == S_EMIT) begin
      out_q <= '0;
      out_q.is_last <= (valid_q == '0);
      out_q.time_ms <= item_q.now_ms;
      out_q.packet_rate <= all_rate_q;
      out_q.live_count <= 4'(live_q);
      out_q.flag_bit <= item_q.sim_active;
    end
    if (emit_go && out_free) begin
      out_q.record_kind <= 1'b1;
      out_q.is_last <= last_rec;
      out_q.record_id <= rdata_i.id;
      out_q.time_ms <= age_pos;
      out_q.packet_rate <= rdata_i.rate;
      out_q.live_count <= '0;
      out_q.lost_total <= rdata_i.lost;
      out_q.report_mv <= rdata_i.info[47:32];
      out_q.fw_version <= rdata_i.info[31:8];
      out_q.report_mode <= rdata_i.info[7:0];
      out_q.flag_bit <= age_lt_link;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/tracker_link_stats_table_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Tracker link statistics table. Slot state sits in one synchronous RAM with
// one read and one write port; per-slot valid bits are flops. Items are taken
// one at a time. A sample/status item runs a full scan, then a
// read-modify-write of the claimed slot, before the next accept. Tick and
// emit-only items run a tick sweep (tick only), a live-count sweep, then one
// record per valid slot, and output stalls can hold them.
module tracker_link_stats_table_top #(
  parameter int unsigned SLOTS = 8,
  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tls_in_if.sink    in_if,
  tls_out_if.source out_if,
  tls_cfg_if.sink   cfg_if
);
  logic [31:0] live_q, link_q, evict_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  tls_pkg::slot_t wdata, rdata;

  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= tls_pkg::LIVE_RST;
      link_q <= tls_pkg::LINK_RST;
      evict_q <= tls_pkg::EVICT_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.data.index)
        tls_pkg::CFG_LIVE:  live_q <= cfg_if.data.data;
        tls_pkg::CFG_LINK:  link_q <= cfg_if.data.data;
        tls_pkg::CFG_EVICT: evict_q <= cfg_if.data.data;
        default: ;
      endcase
    end
  end

  tls_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk_i, .rst_ni, .in_if, .out_if,
    .live_ms_i(live_q), .link_ms_i(link_q), .evict_ms_i(evict_q),
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata), .raddr_o(raddr), .rdata_i(rdata)
  );

  tls_slot_ram #(.SLOTS(SLOTS)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );
endmodule
`default_nettype wire

FILE: rtl/tls_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "tracker_link_stats_table_top_defines.svh"
module tls_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i
);
  `TLS_ASSERT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i, "out dropped")
  `TLS_ASSERT(a_busy, clk_i, rst_ni, out_valid_i |-> !in_ready_i, "input taken mid emit")
  `TLS_ASSERT(a_acc, clk_i, rst_ni, in_valid_i && in_ready_i |=> !in_ready_i, "back to back accept")
  `TLS_ASSERT_RST(a_rst, clk_i, !rst_ni |-> !out_valid_i, "output valid in reset")
endmodule

bind tracker_link_stats_table_top tls_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready)
);
`default_nettype wire

FILE: test/tb_tracker_link_stats_table_top.sv
`timescale 1ns / 1ps
module tb_tracker_link_stats_table_top;
  import tls_pkg::*;

  localparam int NSLOT = 8;
  localparam int N_RAND = 340;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tls_in_if  in_if ();
  tls_out_if out_if ();
  tls_cfg_if cfg_if ();

  tracker_link_stats_table_top #(.SLOTS(NSLOT)) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if.sink),
    .out_if(out_if.source),
    .cfg_if(cfg_if.sink)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // table model
  logic [31:0] live_win, link_win, evict_win;
  logic        t_valid [NSLOT];
  slot_t       t_slot [NSLOT];
  logic [31:0] all_cnt;
  logic [15:0] pkt_rate;

  out_t record_q[$];
  int   n_err = 0;
  int   n_rec = 0;
  int   n_items = 0;
  bit   quiet = 1'b0;
  out_t typed_rec;
  bit   have_typed = 1'b0;

  function automatic longint age_of(logic [31:0] now, int i);
    return longint'(now) - longint'(t_slot[i].seen_ms);
  endfunction

  function automatic void table_reset();
    live_win = LIVE_RST;
    link_win = LINK_RST;
    evict_win = EVICT_RST;
    for (int i = 0; i < NSLOT; i++) begin
      t_valid[i] = 1'b0;
      t_slot[i] = '0;
    end
    all_cnt = '0;
    pkt_rate = '0;
  endfunction

  function automatic void table_config(logic [1:0] idx, logic [31:0] d);
    case (idx)
      CFG_LIVE: live_win = d;
      CFG_LINK: link_win = d;
      CFG_EVICT: evict_win = d;
      default: ;
    endcase
  endfunction

  function automatic int claim_slot(logic [15:0] id, logic [31:0] now);
    int fr, st, k;
    fr = -1;
    st = -1;
    for (int i = 0; i < NSLOT; i++) begin
      if (t_valid[i] && t_slot[i].id == id) return i;
      if (!t_valid[i]) begin
        if (fr < 0) fr = i;
      end else if (age_of(now, i) > longint'(evict_win) && st < 0) begin
        st = i;
      end
    end
    k = (fr >= 0) ? fr : st;
    if (k >= 0) begin
      t_valid[k] = 1'b1;
      t_slot[k] = '0;
      t_slot[k].id = id;
    end
    return k;
  endfunction

  function automatic void table_step(in_t it);
    int k, last;
    logic [15:0] step;
    logic [3:0] live;
    longint ag;
    out_t r;
    if (it.opcode == OP_SAMPLE || it.opcode == OP_STATUS) begin
      all_cnt++;
      k = claim_slot(it.tracker_id, it.now_ms);
      if (k < 0) return;
      t_slot[k].seen_ms = it.now_ms;
      if (it.opcode == OP_SAMPLE) begin
        if (t_slot[k].count != 16'hFFFF) t_slot[k].count++;
        if (!t_slot[k].has_seq) begin
          t_slot[k].has_seq = 1'b1;
          t_slot[k].prev_seq = it.seq_number;
        end else begin
          step = it.seq_number - t_slot[k].prev_seq;
          if (step != 0 && {1'b0, step} <= SEQ_STALE_LIMIT) begin
            t_slot[k].lost += 32'(step) - 32'd1;
            t_slot[k].prev_seq = it.seq_number;
          end
        end
      end else begin
        t_slot[k].info = {it.battery_mv, it.ver_hi, it.ver_mid, it.ver_lo,
                          it.tracker_mode};
      end
      return;
    end
    if (it.opcode == OP_TICK) begin
      pkt_rate = (all_cnt > 32'hFFFF) ? 16'hFFFF : all_cnt[15:0];
      all_cnt = '0;
      for (int i = 0; i < NSLOT; i++) begin
        if (!t_valid[i]) continue;
        t_slot[i].rate = t_slot[i].count;
        t_slot[i].count = '0;
        if (age_of(it.now_ms, i) > longint'(evict_win)) t_valid[i] = 1'b0;
      end
    end
    last = -1;
    live = '0;
    for (int i = 0; i < NSLOT; i++) begin
      if (t_valid[i]) begin
        last = i;
        if (age_of(it.now_ms, i) < longint'(live_win)) live++;
      end
    end
    r = '0;
    r.is_last = (last < 0);
    r.time_ms = it.now_ms;
    r.packet_rate = pkt_rate;
    r.live_count = live;
    r.flag_bit = it.sim_active;
    record_q.push_back(r);
    for (int i = 0; i < NSLOT; i++) begin
      if (!t_valid[i]) continue;
      ag = age_of(it.now_ms, i);
      r = '0;
      r.record_kind = 1'b1;
      r.is_last = (i == last);
      r.record_id = t_slot[i].id;
      r.time_ms = (ag < 0) ? 32'd0 : ag[31:0];
      r.packet_rate = t_slot[i].rate;
      r.lost_total = t_slot[i].lost;
      r.report_mv = t_slot[i].info[47:32];
      r.fw_version = t_slot[i].info[31:8];
      r.report_mode = t_slot[i].info[7:0];
      r.flag_bit = (ag < longint'(link_win));
      record_q.push_back(r);
    end
  endfunction

  task automatic note_mismatch(string what, out_t e, out_t a);
    n_err++;
    if (n_err <= 10)
      $display("mismatch %s: expected %p actual %p", what, e, a);
  endtask

  // output side
  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        if (have_typed) begin
          if (out_if.data !== typed_rec) note_mismatch("typed record", typed_rec, out_if.data);
          have_typed = 1'b0;
        end
        if (record_q.size() == 0) begin
          note_mismatch("unexpected record", '0, out_if.data);
        end else begin
          out_t e;
          e = record_q.pop_front();
          n_rec++;
          if (e !== out_if.data) note_mismatch("record", e, out_if.data);
        end
      end
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // valid stays up into the next item; drain() or an idle burst drops it
  task automatic send_item(in_t it);
    in_if.valid <= 1'b1;
    in_if.data <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    table_step(it);
    n_items++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  task automatic write_regs(logic [31:0] lv, logic [31:0] lk, logic [31:0] ev);
    cfg_t c;
    for (int k = 0; k < 3; k++) begin
      c.index = (k == 0) ? CFG_LIVE : (k == 1) ? CFG_LINK : CFG_EVICT;
      c.data = (k == 0) ? lv : (k == 1) ? lk : ev;
      cfg_if.valid <= 1'b1;
      cfg_if.data <= c;
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
      table_config(c.index, c.data);
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (record_q.size() != 0) @(posedge clk_i);
    repeat (3 * NSLOT + 20) @(posedge clk_i);
  endtask

  function automatic in_t mk(op_e op, logic [15:0] id, logic [15:0] sq,
                             logic [31:0] now);
    in_t it;
    it = '0;
    it.opcode = op;
    it.tracker_id = id;
    it.seq_number = sq;
    it.now_ms = now;
    return it;
  endfunction

  in_t directed [$];
  logic [31:0] clock_ms;

  function automatic in_t rand_item(int pool);
    in_t it;
    int p;
    it = '0;
    it.tracker_id = 16'($urandom_range(0, pool - 1) * 16'h1111);
    if ($urandom_range(0, 15) == 0) it.tracker_id = 16'($urandom);
    p = $urandom_range(0, 99);
    it.opcode = (p < 62) ? OP_SAMPLE : (p < 82) ? OP_STATUS : (p < 93) ? OP_TICK : OP_EMIT;
    it.seq_number = 16'($urandom);
    it.battery_mv = 16'($urandom);
    it.ver_hi = 8'($urandom);
    it.ver_mid = 8'($urandom);
    it.ver_lo = 8'($urandom);
    it.tracker_mode = 8'($urandom);
    it.sim_active = $urandom_range(0, 1);
    p = $urandom_range(0, 19);
    if (p == 0) clock_ms = clock_ms - $urandom_range(0, 5000);
    else if (p == 1) clock_ms = clock_ms + $urandom_range(20000, 80000);
    else if (p == 2) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, 900);
    it.now_ms = clock_ms;
    return it;
  endfunction

  logic [15:0] seq_run [16];

  initial begin
    in_t it;
    in_if.valid <= 1'b0;
    in_if.data <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    table_reset();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset: empty summary
    typed_rec = '0;
    typed_rec.is_last = 1'b1;
    typed_rec.time_ms = 32'hFFFF_FFFF;
    typed_rec.flag_bit = 1'b1;
    have_typed = 1'b1;
    it = mk(OP_EMIT, 0, 0, 32'hFFFF_FFFF);
    it.sim_active = 1'b1;
    send_item(it);
    // sequence handling: first, gap, duplicate, stale, wrap
    directed.push_back(mk(OP_SAMPLE, 16'hFFFF, 16'hFFFE, 100));
    directed.push_back(mk(OP_SAMPLE, 16'hFFFF, 16'h0003, 110));
    directed.push_back(mk(OP_SAMPLE, 16'hFFFF, 16'h0003, 120));
    directed.push_back(mk(OP_SAMPLE, 16'hFFFF, 16'h8004, 130));
    directed.push_back(mk(OP_SAMPLE, 16'hFFFF, 16'h8003, 140));
    it = mk(OP_STATUS, 16'h0000, 0, 150);
    it.battery_mv = 16'hFFFF;
    it.ver_hi = 8'hFF;
    it.ver_mid = 8'h00;
    it.ver_lo = 8'hFF;
    it.tracker_mode = 8'hFF;
    directed.push_back(it);
    for (int i = 1; i < 8; i++) directed.push_back(mk(OP_SAMPLE, 16'(i), 16'(i), 200));
    // table full, no stale slot
    directed.push_back(mk(OP_SAMPLE, 16'h0ABC, 0, 300));
    directed.push_back(mk(OP_TICK, 0, 0, 400));
    // negative age
    directed.push_back(mk(OP_EMIT, 0, 0, 50));
    // stale slot reused
    directed.push_back(mk(OP_STATUS, 16'h0ABC, 0, 30400));
    directed.push_back(mk(OP_TICK, 0, 0, 32'hFFFF_FFFF));
    directed.push_back(mk(OP_TICK, 0, 0, 0));
    foreach (directed[i]) send_item(directed[i]);
    drain();

    write_regs(32'hFFFF_FFFF, 32'd0, 32'd0);
    clock_ms = 1000;
    for (int i = 0; i < 16; i++) seq_run[i] = 16'($urandom);
    for (int n = 0; n < N_RAND; n++) begin
      if (n == N_RAND - 60) quiet = 1'b1;
      if (n % 90 == 89) begin
        drain();
        case (n / 90)
          0: write_regs(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
          1: write_regs($urandom_range(100, 5000), $urandom_range(100, 2000),
                        $urandom_range(1000, 40000));
          default: write_regs(LIVE_RST, LINK_RST, EVICT_RST);
        endcase
      end
      it = rand_item((n / 60) % 2 ? 12 : 6);
      if (it.opcode == OP_SAMPLE && $urandom_range(0, 3) != 0) begin
        seq_run[it.tracker_id[3:0]] += 16'($urandom_range(1, 3));
        it.seq_number = seq_run[it.tracker_id[3:0]];
      end
      send_item(it);
    end
    // burst on one tracker, then a tick
    for (int n = 0; n < 20; n++) send_item(mk(OP_SAMPLE, 16'h5555, 16'(n), clock_ms));
    send_item(mk(OP_TICK, 0, 0, clock_ms));
    drain();

    $display("%0d items sent, %0d records checked across 4 register settings",
             n_items, n_rec);
    if (n_err == 0 && record_q.size() == 0) begin
      $display("[tracker_link_stats_table_top] OK");
    end else begin
      $display("mismatches %0d, records left %0d", n_err, record_q.size());
      $display("[tracker_link_stats_table_top] ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("[tracker_link_stats_table_top] ERROR");
    $finish;
  end
endmodule
